[rtl/core/rnta_pkg.sv]
// Shared constants, types and digit encoding for the radix number to ASCII converter.
package rnta_pkg;

    localparam int VALUE_BITS    = 16;
    localparam int VALUE_IN_W    = 16;
    localparam int RADIX_W       = 6;
    localparam int DIGIT_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_DEPTH   = VALUE_BITS;
    localparam int IDX_W         = $clog2(DIGIT_DEPTH);
    localparam int CNT_W         = $clog2(DIGIT_DEPTH + 1);
    localparam int STEP_W        = $clog2(VALUE_BITS);
    localparam int S_DATA_W      = ((VALUE_IN_W + RADIX_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((CHAR_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] MAX_RADIX     = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(8'h41);

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    function automatic char_t digit_char(input digit_t d);
        char_t c;
        if (d < DECIMAL_LIMIT)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT);
        end
        return c;
    endfunction

endpackage

[rtl/core/radix_number_to_ascii.sv]
// Radix number to ASCII converter: bit-serial divider under a small sequencer.
// Each digit takes VALUE_BITS restoring divide steps followed by one store step.
// A value yields D digits (up to 16); a zero value or a flagged base skips the divider
// and goes straight from the idle state to the emit state.
// Characters then leave at one per cycle while the sink is ready.
// A new request is taken only after the last character has been loaded for output.
// Reset (rst_n low, asynchronous) clears the sequencer, counters and output valid.
module radix_number_to_ascii (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value [15:0], radix [21:16], zero fill [23:22]
    input  logic [rnta_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // character [6:0], zero fill [7]
    output logic [rnta_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast,
    // bad_base [0]
    output logic                           m_axis_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [rnta_pkg::VALUE_BITS-1:0]     quo_reg, quo_next;
    logic [rnta_pkg::DIGIT_W-1:0]        rem_reg, rem_next;
    logic [rnta_pkg::RADIX_W-1:0]        radix_reg, radix_next;
    logic [rnta_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [rnta_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                                bad_reg, bad_next;
    logic                                out_valid_reg, out_valid_next;
    rnta_pkg::char_t                     out_char_reg, out_char_next;
    logic                                out_last_reg, out_last_next;
    logic                                out_bad_reg, out_bad_next;

    rnta_pkg::digit_t                    digit_store [rnta_pkg::DIGIT_DEPTH];

    logic [rnta_pkg::VALUE_IN_W-1:0]     in_value;
    logic [rnta_pkg::RADIX_W-1:0]        in_radix;
    logic                                in_accept;
    logic                                in_bad;
    logic [rnta_pkg::DIGIT_W:0]          trial;
    logic                                trial_ge;
    logic                                store_we;
    logic [rnta_pkg::IDX_W-1:0]          store_idx;
    rnta_pkg::digit_t                    store_data;
    logic [rnta_pkg::IDX_W-1:0]          emit_idx;
    logic                                out_free;

    assign in_value  = s_axis_tdata[rnta_pkg::VALUE_IN_W-1:0];
    assign in_radix  = s_axis_tdata[rnta_pkg::VALUE_IN_W +: rnta_pkg::RADIX_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_bad    = (in_radix < rnta_pkg::MIN_RADIX) || (in_radix > rnta_pkg::MAX_RADIX);

    assign trial    = {rem_reg, quo_reg[rnta_pkg::VALUE_BITS-1]};
    assign trial_ge = trial >= (rnta_pkg::DIGIT_W + 1)'(radix_reg);
    assign emit_idx = rnta_pkg::IDX_W'(cnt_reg - rnta_pkg::CNT_W'(1));
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rnta_pkg::M_DATA_W'(out_char_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        store_we       = 1'b0;
        store_idx      = cnt_reg[rnta_pkg::IDX_W-1:0];
        store_data     = rem_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    quo_next   = rnta_pkg::VALUE_BITS'(in_value);
                    rem_next   = '0;
                    radix_next = in_radix;
                    step_next  = '0;
                    bad_next   = in_bad;
                    if (in_bad)
                    begin
                        cnt_next   = rnta_pkg::CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                    else if (rnta_pkg::VALUE_BITS'(in_value) == '0)
                    begin
                        store_we   = 1'b1;
                        store_idx  = '0;
                        store_data = '0;
                        cnt_next   = rnta_pkg::CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[rnta_pkg::VALUE_BITS-2:0], trial_ge};
                if (trial_ge)
                begin
                    rem_next = rnta_pkg::DIGIT_W'(trial - (rnta_pkg::DIGIT_W + 1)'(radix_reg));
                end
                else
                begin
                    rem_next = trial[rnta_pkg::DIGIT_W-1:0];
                end
                step_next = step_reg + rnta_pkg::STEP_W'(1);
                if (step_reg == rnta_pkg::STEP_W'(rnta_pkg::VALUE_BITS - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                store_we  = 1'b1;
                cnt_next  = cnt_reg + rnta_pkg::CNT_W'(1);
                rem_next  = '0;
                step_next = '0;
                if ((quo_reg == '0) ||
                    (cnt_reg == rnta_pkg::CNT_W'(rnta_pkg::DIGIT_DEPTH - 1)))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    out_last_next  = (cnt_reg == rnta_pkg::CNT_W'(1));
                    out_char_next  = bad_reg ? '0 : rnta_pkg::digit_char(digit_store[emit_idx]);
                    cnt_next       = cnt_reg - rnta_pkg::CNT_W'(1);
                    if (cnt_reg == rnta_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            radix_reg     <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[store_idx] <= store_data;
        end
    end

    // The partial remainder of the divider always stays below the base.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((rnta_pkg::RADIX_W)'(rem_reg) < radix_reg))
        else $error("divider remainder not below radix");

    // The digit count never runs past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rnta_pkg::CNT_W'(rnta_pkg::DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    // A flagged base goes out as a single zero character marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_last_reg && (out_char_reg == '0)))
        else $error("bad base result malformed");

    // An accepted request keeps the input closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input reopened right after a request");

endmodule
